@@ rtl/core/tsps_pkg.sv @@
// Shared types, register map and coil phase tables for the stepper phase sequencer.
`timescale 1ns / 1ps
`default_nettype none
package tsps_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REG_STEP_MODE     = 2'd0;
    localparam logic [1:0] REG_REV_LENGTH    = 2'd1;
    localparam logic [1:0] REG_STEP_INTERVAL = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    localparam logic [15:0] REV_LENGTH_RESET    = 16'd200;
    localparam logic [31:0] STEP_INTERVAL_RESET = 32'd1000;

    typedef struct packed {
        logic        is_move;
        logic [14:0] magnitude;
        logic        forward;
    } queue_entry_t;

    typedef struct packed {
        logic        rejected;
        logic        busy_res;
        logic        stepped;
        logic [15:0] rotor_position;
        logic [3:0]  coil_pattern;
    } result_t;

    typedef struct packed {
        logic        step_mode;
        logic [15:0] rev_length;
        logic [31:0] step_interval;
    } config_t;

    function automatic logic [3:0] full_phase(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h5;
            2'd3:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

    function automatic logic [3:0] half_phase(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hA;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'h5;
            3'd6:    pat = 4'h1;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/timed_stepper_phase_sequencer_unit.sv @@
// Top level of the timed stepper phase sequencer: stream ports, register file, front and back.
//
// Input stream (s_*): each item is a tick (s_tuser = 0) or a move command
// (s_tuser = 1) carrying a signed step count in s_tdata. Output stream (m_*):
// one result per item with coil pattern, rotor position and status flags.
// Registers over APB: 0x0 step_mode, 0x4 revolution length, 0x8 step_interval.
// Write them only while no item is in flight.
// Flow: an accepted item is written into the queue, and the step engine then
// pops it and loads its output register, which raises m_tvalid.
// Throughput: one item per cycle while m_tready stays high; the step engine does
// one compare, one position update and one table lookup per item.
// A stalled receiver holds the output register; the queue absorbs up to two
// items before s_tready drops, and items resume at full rate once m_tready
// returns. Reset clears the tick history, position, pending steps and coils
// and restores registers to full step, 200 steps/rev, interval 1000.
`timescale 1ns / 1ps
`default_nettype none
module timed_stepper_phase_sequencer_unit
    import tsps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] step_count
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] coil_pattern, [19:4] rotor_position,
                                        // [20] stepped, [21] busy_res, [22] rejected
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    config_t      cfg_reg;
    queue_entry_t front_entry;
    queue_entry_t head;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;
    result_t      res;
    logic         wr_en;
    logic [1:0]   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_mode     <= 1'b0;
            cfg_reg.rev_length    <= REV_LENGTH_RESET;
            cfg_reg.step_interval <= STEP_INTERVAL_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEP_MODE:     cfg_reg.step_mode     <= pwdata[0];
                REG_REV_LENGTH:    cfg_reg.rev_length    <= pwdata[15:0];
                REG_STEP_INTERVAL: cfg_reg.step_interval <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STEP_MODE:     prdata = {31'd0, cfg_reg.step_mode};
            REG_REV_LENGTH:    prdata = {16'd0, cfg_reg.rev_length};
            REG_STEP_INTERVAL: prdata = cfg_reg.step_interval;
            default:           prdata = 32'd0;
        endcase
    end

    tsps_front u_front (
        .command    (s_tuser[0]),
        .step_count (s_tdata),
        .entry      (front_entry)
    );

    assign s_tready = !q_full;

    tsps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty)
    );

    tsps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (head),
        .item_valid (q_not_empty),
        .item_pop   (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {1'b0, res.rejected, res.busy_res, res.stepped,
                      res.rotor_position, res.coil_pattern};

endmodule
`default_nettype wire

@@ rtl/core/tsps_front.sv @@
// Front end: classifies each input item and decodes move magnitude and direction.
`timescale 1ns / 1ps
`default_nettype none
module tsps_front
    import tsps_pkg::*;
(
    input  wire logic               command,
    input  wire logic signed [15:0] step_count,
    output queue_entry_t            entry
);

    logic        negative;
    logic [15:0] neg_mag;
    logic [14:0] magnitude;

    assign negative = step_count[15];
    assign neg_mag  = 16'd0 - step_count;

    always_comb
    begin
        if (!negative)
        begin
            magnitude = step_count[14:0];
        end
        else if (neg_mag[15])
        begin
            magnitude = 15'h7FFF;
        end
        else
        begin
            magnitude = neg_mag[14:0];
        end
    end

    assign entry.is_move   = (command == CMD_MOVE);
    assign entry.magnitude = magnitude;
    assign entry.forward   = !negative && (step_count != 16'sd0);

endmodule
`default_nettype wire

@@ rtl/core/tsps_queue.sv @@
// Short queue that decouples the front end from the step engine.
`timescale 1ns / 1ps
`default_nettype none
module tsps_queue
    import tsps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire queue_entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output queue_entry_t head,
    output logic        not_empty
);

    localparam logic [QUEUE_AW:0] DEPTH_CNT = QUEUE_AW'(QUEUE_DEPTH) == '0 ?
        (QUEUE_AW + 1)'(QUEUE_DEPTH) : (QUEUE_AW + 1)'(QUEUE_DEPTH);

    queue_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tsps_back.sv @@
// Step engine: applies queued items to the motion state and registers one result per item.
`timescale 1ns / 1ps
`default_nettype none
module tsps_back
    import tsps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire config_t cfg,
    input  wire queue_entry_t item,
    input  wire logic   item_valid,
    output logic        item_pop,
    output logic        res_valid,
    input  wire logic   res_ready,
    output result_t     res
);

    logic [31:0] elapsed_reg, elapsed_next;
    logic [15:0] position_reg, position_next;
    logic [14:0] remaining_reg, remaining_next;
    logic        forward_reg, forward_next;
    logic [3:0]  coil_reg, coil_next;
    logic        res_valid_reg;
    result_t     res_reg, res_next;

    logic        accept_move;
    logic        rejected;
    logic [14:0] rem_a;
    logic        fwd_a;
    logic [31:0] elapsed_a;
    logic        do_step;
    logic [16:0] modulus;
    logic [16:0] pos_inc;
    logic [15:0] pos_stepped;

    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign accept_move = item.is_move && (remaining_reg == '0);
    assign rejected    = item.is_move && (remaining_reg != '0);
    assign rem_a       = accept_move ? item.magnitude : remaining_reg;
    assign fwd_a       = accept_move ? item.forward : forward_reg;
    assign elapsed_a   = item.is_move ? elapsed_reg : elapsed_reg + 32'd1;
    assign do_step     = (rem_a != '0) && (elapsed_a >= cfg.step_interval);

    assign modulus = (cfg.rev_length == '0) ? 17'h10000 : {1'b0, cfg.rev_length};
    assign pos_inc = {1'b0, position_reg} + 17'd1;

    always_comb
    begin
        if (fwd_a)
        begin
            pos_stepped = (pos_inc >= modulus) ? 16'd0 : pos_inc[15:0];
        end
        else if ((position_reg == '0) || ({1'b0, position_reg} >= modulus))
        begin
            pos_stepped = 16'(modulus - 17'd1);
        end
        else
        begin
            pos_stepped = position_reg - 16'd1;
        end
    end

    always_comb
    begin
        elapsed_next   = elapsed_reg;
        position_next  = position_reg;
        remaining_next = remaining_reg;
        forward_next   = forward_reg;
        coil_next      = coil_reg;
        if (item_pop)
        begin
            forward_next   = fwd_a;
            remaining_next = rem_a;
            elapsed_next   = elapsed_a;
            if (do_step)
            begin
                position_next  = pos_stepped;
                coil_next      = cfg.step_mode ? half_phase(pos_stepped[2:0]) :
                                                 full_phase(pos_stepped[1:0]);
                elapsed_next   = '0;
                remaining_next = rem_a - 15'd1;
            end
        end
        res_next.coil_pattern   = coil_next;
        res_next.rotor_position = position_next;
        res_next.stepped        = do_step;
        res_next.busy_res       = (remaining_next != '0);
        res_next.rejected       = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            position_reg  <= '0;
            remaining_reg <= '0;
            forward_reg   <= 1'b0;
            coil_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg   <= elapsed_next;
            position_reg  <= position_next;
            remaining_reg <= remaining_next;
            forward_reg   <= forward_next;
            coil_reg      <= coil_next;
            if (item_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking stream testbench for the timed stepper phase sequencer unit.
`timescale 1ns / 1ps
module testbench
    import tsps_pkg::*;
;

    typedef struct packed {
        logic        cmd;
        logic [15:0] count;
    } motor_cmd_t;

    localparam logic [15:0] FULL_COILS = 16'h956A;
    localparam logic [31:0] HALF_COILS = 32'h915462A8;
    localparam int          LONG_HOLD  = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [3:0] coil_pattern, [19:4] rotor_position,
                            // [20] stepped, [21] busy_res, [22] rejected
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timed_stepper_phase_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    motor_cmd_t  motor_cmds[$];
    result_t     motor_results_due[$];
    motor_cmd_t  next_cmd;
    result_t     forecast;
    result_t     observed;

    logic [31:0] tick_count = '0;
    logic [31:0] last_step_tick = '0;
    logic [15:0] rotor = '0;
    logic [14:0] steps_left = '0;
    logic        move_fwd = 1'b0;
    logic [3:0]  coils = '0;
    logic        cfg_half = 1'b0;
    logic [15:0] cfg_spr = REV_LENGTH_RESET;
    logic [31:0] cfg_interval = STEP_INTERVAL_RESET;

    int sender_idle_pct = 22;
    int rcv_idle_pct = 50;
    int long_hold_req = 0;
    int long_hold_served = 0;
    int hold_left = 0;
    int cmds_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int steps_seen = 0;
    int rejects_seen = 0;
    int mismatches = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic result_t advance_motor(input logic cmd, input logic [15:0] count);
        result_t     r;
        logic [16:0] mag;
        logic [16:0] wrap;
        r = '0;
        if (cmd == CMD_TICK)
            tick_count = tick_count + 32'd1;
        else if (steps_left != '0)
            r.rejected = 1'b1;
        else
        begin
            mag = count[15] ? 17'h10000 - {1'b0, count} : {1'b0, count};
            if (mag > 17'h07FFF)
                mag = 17'h07FFF;
            move_fwd = !count[15] && (count != '0);
            steps_left = mag[14:0];
        end
        if (steps_left != '0 && (tick_count - last_step_tick) >= cfg_interval)
        begin
            wrap = (cfg_spr == '0) ? 17'h10000 : {1'b0, cfg_spr};
            if (move_fwd)
                rotor = ({1'b0, rotor} + 17'd1 >= wrap) ? 16'd0 : rotor + 16'd1;
            else if (rotor == '0 || {1'b0, rotor} >= wrap)
                rotor = 16'(wrap - 17'd1);
            else
                rotor = rotor - 16'd1;
            coils = cfg_half ? HALF_COILS[rotor[2:0] * 4 +: 4] : FULL_COILS[rotor[1:0] * 4 +: 4];
            last_step_tick = tick_count;
            steps_left = steps_left - 15'd1;
            r.stepped = 1'b1;
        end
        r.coil_pattern = coils;
        r.rotor_position = rotor;
        r.busy_res = (steps_left != '0);
        return r;
    endfunction

    function automatic void push_move(input logic [15:0] count);
        motor_cmds.push_back('{cmd: CMD_MOVE, count: count});
        cmds_queued++;
    endfunction

    function automatic void push_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            motor_cmds.push_back('{cmd: CMD_TICK, count: 16'($urandom())});
            cmds_queued++;
        end
    endfunction

    task automatic drain();
        while (motor_cmds.size() != 0 || s_tvalid || motor_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_motion(input logic mode, input logic [15:0] spr, input logic [31:0] iv);
        drain();
        repeat (3) @(posedge clk);
        write_reg(REG_STEP_MODE, {31'b0, mode});
        write_reg(REG_REV_LENGTH, {16'b0, spr});
        write_reg(REG_STEP_INTERVAL, iv);
        cfg_half = mode;
        cfg_spr = spr;
        cfg_interval = iv;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (motor_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_cmd = motor_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_cmd.cmd;
                s_tdata <= next_cmd.count;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_req != long_hold_served)
        begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_served <= long_hold_req;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                forecast = advance_motor(s_tuser[0], s_tdata);
                motor_results_due.push_back(forecast);
                items_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                observed = result_t'(m_tdata[22:0]);
                if (motor_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h with nothing pending", m_tdata);
                end
                else
                begin
                    forecast = motor_results_due.pop_front();
                    results_checked++;
                    if (observed.stepped)
                        steps_seen++;
                    if (observed.rejected)
                        rejects_seen++;
                    if (observed.coil_pattern !== forecast.coil_pattern
                        || observed.rotor_position !== forecast.rotor_position
                        || observed.stepped !== forecast.stepped
                        || observed.busy_res !== forecast.busy_res
                        || observed.rejected !== forecast.rejected
                        || m_tdata[23] !== 1'b0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp coil %h pos %0d step %b busy %b rej %b,",
                                     results_checked, forecast.coil_pattern,
                                     forecast.rotor_position, forecast.stepped,
                                     forecast.busy_res, forecast.rejected,
                                     " got coil %h pos %0d step %b busy %b rej %b pad %b",
                                     observed.coil_pattern, observed.rotor_position,
                                     observed.stepped, observed.busy_res,
                                     observed.rejected, m_tdata[23]);
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int          ph;
        int          iv;
        int          steps;
        int          run;
        int          since;
        int          phase_start;
        logic [15:0] count;
        logic [15:0] spr;
        logic        mode;
        bit          clean;
        bit          prev_broken;
        bit          broken;
        bit          paused;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: long interval, nothing steps yet
        push_ticks(1);
        push_move(16'd3);
        push_move(-16'sd5);
        push_ticks(1);

        // zero interval: step on every item while steps remain, rejected move still steps
        set_motion(1'b0, 16'd200, 32'd0);
        push_ticks(1);
        push_move(16'd7);
        push_ticks(2);
        push_move(16'd0);
        push_move(16'd2);
        push_ticks(1);
        push_move(-16'sd2);
        push_ticks(1);

        // full 16-bit wrap, reverse through zero
        set_motion(1'b1, 16'd0, 32'd1);
        push_move(-16'sd6);
        push_ticks(7);

        // position beyond the revolution, reverse then forward
        set_motion(1'b0, 16'd5, 32'd0);
        push_move(-16'sd1);
        set_motion(1'b1, 16'd3, 32'hFFFF_FFFF);
        push_move(16'd1);
        push_ticks(1);
        set_motion(1'b1, 16'd3, 32'd0);
        push_ticks(1);

        paused = 1'b0;
        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                sender_idle_pct = 50;
                rcv_idle_pct = 22;
            end
            if (ph == 6)
            begin
                sender_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case ($urandom_range(0, 6))
                0: spr = 16'd1;
                1: spr = 16'd4;
                2: spr = 16'd8;
                3: spr = 16'd200;
                4: spr = 16'd65535;
                5: spr = 16'd0;
                default: spr = 16'($urandom_range(1, 65535));
            endcase
            iv = $urandom_range(0, 4);
            mode = 1'($urandom_range(0, 1));
            if (ph == 0)
                mode = 1'b0;
            if (ph == 1)
                mode = 1'b1;
            set_motion(mode, spr, iv);
            if (ph == 1 || ph == 5)
                long_hold_req++;
            phase_start = cmds_queued;
            prev_broken = 1'b1;
            while (cmds_queued - phase_start < 200)
            begin
                if (ph == 4 && !paused && cmds_queued - phase_start >= 100)
                begin
                    drain();
                    paused = 1'b1;
                end
                clean = !prev_broken;
                steps = $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0)
                    steps = $urandom_range(13, 60);
                count = 16'(steps);
                if ($urandom_range(0, 1) == 1)
                    count = -count;
                if ($urandom_range(0, 19) == 0)
                    count = '0;
                push_move(count);
                broken = ($urandom_range(0, 99) < 15);
                if (prev_broken)
                    run = 61 * (iv + 1) + 2;
                else if (broken)
                    run = $urandom_range(0, steps);
                else if (count == '0)
                    run = $urandom_range(0, 3);
                else
                    run = steps * (iv + 1) + $urandom_range(0, 2);
                since = 0;
                for (int k = 0; k < run; k++)
                begin
                    if (clean && count != '0 && since < steps - 1 && $urandom_range(0, 99) < 10)
                    begin
                        push_move(16'($urandom()));
                        since++;
                    end
                    push_ticks(1);
                    since++;
                end
                prev_broken = broken && !prev_broken;
            end
        end

        // most negative count saturates to a full reverse run
        set_motion(1'b0, 16'd200, 32'd0);
        push_ticks(70);
        push_move(16'h8000);
        push_ticks(8);

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d items and %0d results: %0d steps, %0d rejected moves",
                 items_taken, results_checked, steps_seen, rejects_seen);
        $display("settings: full and half step, wrap 1..65536, interval 0..4 and max");
        if (mismatches == 0 && motor_results_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
